// ----- sv/bbr_pkg.sv -----
// Shared types and constants for the supply brown-out backlight ramp block.
`default_nettype none

package bbr_pkg;

    localparam int MV_W       = 14;
    localparam int TIME_W     = 32;
    localparam int INTERVAL_W = 16;
    localparam int LEVEL_W    = 8;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // brightness mode codes; the fourth code selects the night target
    localparam logic [MODE_W-1:0] MODE_DAY   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DUSK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NIGHT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_REDUCE  = 2'd1,
        ACT_STEP    = 2'd2,
        ACT_RESTORE = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_THRESHOLD     = 3'd0,
        REG_RECOVER_THRESHOLD = 3'd1,
        REG_CHECK_INTERVAL    = 3'd2,
        REG_LEVEL_DAY         = 3'd3,
        REG_LEVEL_DUSK        = 3'd4,
        REG_LEVEL_NIGHT       = 3'd5,
        REG_RAMP_STEP         = 3'd6,
        REG_RAMP_INTERVAL     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [MV_W-1:0]       low_threshold_mv;
        logic [MV_W-1:0]       recover_threshold_mv;
        logic [INTERVAL_W-1:0] check_interval_ms;
        logic [LEVEL_W-1:0]    level_day;
        logic [LEVEL_W-1:0]    level_dusk;
        logic [LEVEL_W-1:0]    level_night;
        logic [LEVEL_W-1:0]    ramp_step;
        logic [INTERVAL_W-1:0] ramp_interval_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        low_threshold_mv:     14'd4500,
        recover_threshold_mv: 14'd4750,
        check_interval_ms:    16'd500,
        level_day:            8'd255,
        level_dusk:           8'd120,
        level_night:          8'd30,
        ramp_step:            8'd10,
        ramp_interval_ms:     16'd100
    };

    typedef struct packed {
        logic [MV_W-1:0]   vbus_mv;
        logic [TIME_W-1:0] now_ms;
        logic [MODE_W-1:0] current_mode;
    } in_item_t;

    typedef struct packed {
        action_t            action;
        logic [LEVEL_W-1:0] ramp_level;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/vbus_brownout_backlight_ramp_top.sv -----
// Top level of the supply brown-out backlight ramp block: item stages and ports.
//
// Usage:
//   s_valid/s_ready/s_data carry one item: a supply sample in mV, a wrapping
//   ms timestamp and the current brightness mode. m_valid/m_ready/m_data
//   return exactly one result item per input item: an action code
//   (none, reduce, step, restore) and the ramp level after the update.
//   cfg_wr_en/cfg_index/cfg_wdata write one of the eight setup registers,
//   chosen by cfg_index, per write; write them only while no item is in flight.
// Path: an accepted item is held in the item register; its result is then
//   registered in the result register, which drives m_valid, and waits
//   there until it is taken.
// Throughput: one item per cycle while m_ready is high. The state update is
//   a single pass of compares and one 9-bit add between the item register
//   and the result register, so the next item sees the new state immediately.
// Reset (aresetn low, synchronous): both stages empty, timestamps, flags,
//   saved mode and level cleared, registers back to their defaults.
// Stall: while m_ready is low the result holds; the item register still
//   takes one more item, then s_ready drops until the result is taken.
`default_nettype none

module vbus_brownout_backlight_ramp_top
    import bbr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  in_item_t                   s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t      cfg;
    in_item_t  in_item_reg;
    logic      in_valid_reg;
    out_item_t out_item_reg;
    logic      out_valid_reg;
    out_item_t result;
    logic      advance;

    // move the held item into the result register when that slot frees up
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bbr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bbr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // item register: load on accept, drop once forwarded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // result register: hold while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    a_item_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held item did not reach the result register");

    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are full");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("stages not empty after reset");

endmodule

`default_nettype wire

// ----- sv/bbr_cfg.sv -----
// Configuration register file for the brown-out backlight ramp block.
`default_nettype none

module bbr_cfg
    import bbr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                REG_LOW_THRESHOLD:     cfg_next.low_threshold_mv     = cfg_wdata[MV_W-1:0];
                REG_RECOVER_THRESHOLD: cfg_next.recover_threshold_mv = cfg_wdata[MV_W-1:0];
                REG_CHECK_INTERVAL:    cfg_next.check_interval_ms    = cfg_wdata;
                REG_LEVEL_DAY:         cfg_next.level_day            = cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_DUSK:        cfg_next.level_dusk           = cfg_wdata[LEVEL_W-1:0];
                REG_LEVEL_NIGHT:       cfg_next.level_night          = cfg_wdata[LEVEL_W-1:0];
                REG_RAMP_STEP:         cfg_next.ramp_step            = cfg_wdata[LEVEL_W-1:0];
                REG_RAMP_INTERVAL:     cfg_next.ramp_interval_ms     = cfg_wdata;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/bbr_core.sv -----
// Hysteresis check and recovery ramp state with its single-pass update logic.
`default_nettype none

module bbr_core
    import bbr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  cfg_t      cfg,
    input  wire logic advance,
    input  in_item_t  item,
    output out_item_t result
);

    logic [TIME_W-1:0]  last_check_reg, last_check_next;
    logic [TIME_W-1:0]  last_step_reg, last_step_next;
    logic               voltage_low_reg, voltage_low_next;
    logic               recovering_reg, recovering_next;
    logic [MODE_W-1:0]  saved_mode_reg, saved_mode_next;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic [TIME_W-1:0]  check_elapsed;
    logic [TIME_W-1:0]  step_elapsed;
    logic [LEVEL_W-1:0] target;
    logic [LEVEL_W:0]   ramp_sum;
    action_t            action;

    always_comb begin
        last_check_next  = last_check_reg;
        last_step_next   = last_step_reg;
        voltage_low_next = voltage_low_reg;
        recovering_next  = recovering_reg;
        saved_mode_next  = saved_mode_reg;
        level_next       = level_reg;
        action           = ACT_NONE;

        // voltage check with hysteresis
        check_elapsed = item.now_ms - last_check_reg;
        if (check_elapsed >= TIME_W'(cfg.check_interval_ms)) begin
            if (!voltage_low_reg && (item.vbus_mv < cfg.low_threshold_mv)) begin
                voltage_low_next = 1'b1;
                saved_mode_next  = item.current_mode;
                level_next       = cfg.level_night;
                action           = ACT_REDUCE;
            end else if (voltage_low_reg && (item.vbus_mv >= cfg.recover_threshold_mv)) begin
                voltage_low_next = 1'b0;
                recovering_next  = 1'b1;
                last_step_next   = item.now_ms;
            end
            last_check_next = item.now_ms;
        end

        unique case (saved_mode_next)
            MODE_DAY:  target = cfg.level_day;
            MODE_DUSK: target = cfg.level_dusk;
            default:   target = cfg.level_night;
        endcase

        // ramp toward the saved target; the sum is kept at nine bits
        step_elapsed = item.now_ms - last_step_next;
        ramp_sum     = {1'b0, level_next} + {1'b0, cfg.ramp_step};
        if (recovering_next) begin
            if ((level_next < target) &&
                (step_elapsed >= TIME_W'(cfg.ramp_interval_ms))) begin
                level_next     = (ramp_sum < {1'b0, target}) ? ramp_sum[LEVEL_W-1:0] : target;
                last_step_next = item.now_ms;
                action         = ACT_STEP;
            end
            if (level_next >= target) begin
                recovering_next = 1'b0;
                action          = ACT_RESTORE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_check_reg  <= '0;
            last_step_reg   <= '0;
            voltage_low_reg <= 1'b0;
            recovering_reg  <= 1'b0;
            saved_mode_reg  <= MODE_DAY;
            level_reg       <= '0;
        end else if (advance) begin
            last_check_reg  <= last_check_next;
            last_step_reg   <= last_step_next;
            voltage_low_reg <= voltage_low_next;
            recovering_reg  <= recovering_next;
            saved_mode_reg  <= saved_mode_next;
            level_reg       <= level_next;
        end
    end

    assign result.action     = action;
    assign result.ramp_level = level_next;

    a_restore_ends_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action == ACT_RESTORE)) |=> !recovering_reg)
        else $error("restore left the ramp running");

    a_reduce_marks_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action == ACT_REDUCE)) |=>
            (voltage_low_reg && (level_reg == $past(cfg.level_night))))
        else $error("reduce did not mark the supply low at the night level");

    a_step_stamps_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (action == ACT_STEP)) |=> (last_step_reg == $past(item.now_ms)))
        else $error("step did not record its timestamp");

endmodule

`default_nettype wire
